// ===== src/ycc420_pkg.sv =====
// Shared constants and widths of the RGB to YCoCg-R 4:2:0 converter.
`timescale 1ns / 1ps

package ycc420_pkg;

    localparam int COMP_W       = 8;
    localparam int CFG_W        = 13;
    localparam int MAX_WIDTH    = 4096;
    localparam int PAIR_DEPTH   = MAX_WIDTH / 2;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int PAIR_AW      = $clog2(PAIR_DEPTH);
    localparam int WCMP_W       = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
    localparam int CHROMA_W     = 9;
    localparam int SUM_W        = 11;
    localparam int PAIR_W       = 2 * SUM_W;
    localparam int TOTAL_W      = 12;
    localparam int ROUND_OFFSET = 1024;
    localparam int SUB_SHIFT    = 3;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = CFG_W'(1920);

    typedef logic [COMP_W-1:0] t_comp;
    typedef logic [CFG_W-1:0]  t_cfg_width;

endpackage

// ===== src/ycc420_if.sv =====
// Valid/ready channel interfaces for pixels, results and the width register.
`timescale 1ns / 1ps

interface ycc420_pix_if import ycc420_pkg::*; ();
    logic  valid;
    logic  ready;
    t_comp red;
    t_comp green;
    t_comp blue;
    logic  frame_start;

    modport source (output valid, output red, output green, output blue,
                    output frame_start, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input frame_start, output ready);
endinterface

interface ycc420_res_if import ycc420_pkg::*; ();
    logic  valid;
    logic  ready;
    t_comp luma;
    logic  chroma_valid;
    t_comp co_sub;
    t_comp cg_sub;

    modport source (output valid, output luma, output chroma_valid, output co_sub,
                    output cg_sub, input ready);
    modport sink   (input valid, input luma, input chroma_valid, input co_sub,
                    input cg_sub, output ready);
endinterface

interface ycc420_cfg_if import ycc420_pkg::*; ();
    logic       valid;
    logic       ready;
    t_cfg_width line_width;

    modport source (output valid, output line_width, input ready);
    modport sink   (input valid, input line_width, output ready);
endinterface

// ===== src/rgb_to_ycocg_r_420.sv =====
// Top level: streaming RGB to YCoCg-R converter with 4:2:0 chroma subsampling.
// A pixel request goes through stage one, then the output register, before it is on o_res.
// Throughput: one pixel per clock while o_res is not stalled; the line store takes one write
// or one read per pixel and registers its read data.
// Reset clears position, parity, left chroma and pipeline valids and sets the width to 1920.
// Store not cleared; the user, unchecked, keeps odd-row reads to entries even rows wrote.
`timescale 1ns / 1ps

module rgb_to_ycocg_r_420 import ycc420_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    ycc420_pix_if.sink          i_pix,
    ycc420_res_if.source        o_res,
    ycc420_cfg_if.sink          i_cfg
);

    // Configuration and position state.
    logic [CFG_W-1:0]          r_line_width;
    logic [COL_W-1:0]          r_col;
    logic                      r_row_odd;
    logic signed [CHROMA_W-1:0] r_left_co;
    logic signed [CHROMA_W-1:0] r_left_cg;

    // Line store of even-row pair sums, {co_pair, cg_pair} per column pair.
    logic [PAIR_W-1:0]         r_pair_mem [PAIR_DEPTH];
    logic [PAIR_W-1:0]         r_rd_data;

    // Stage one: luma and this row's pair sums, waiting for the store read.
    logic                      r_s1_valid;
    t_comp                     r_s1_luma;
    logic                      r_s1_chroma;
    logic signed [SUM_W-1:0]   r_s1_sco;
    logic signed [SUM_W-1:0]   r_s1_scg;

    // Output register.
    logic                      r_out_valid;
    t_comp                     r_out_luma;
    logic                      r_out_chroma;
    t_comp                     r_out_co;
    t_comp                     r_out_cg;

    logic                      pix_acc;
    logic                      s1_adv;
    logic [WCMP_W-1:0]         w_cfg;
    logic [WCMP_W-1:0]         w_eff;
    logic [COL_W-1:0]          eff_col;
    logic                      eff_odd;
    logic                      line_end;
    logic signed [9:0]         co;
    logic signed [9:0]         lift_t;
    logic signed [9:0]         cg;
    logic signed [9:0]         y_val;
    logic signed [SUM_W-1:0]   sco;
    logic signed [SUM_W-1:0]   scg;
    logic [PAIR_AW-1:0]        slot;
    logic                      mem_we;
    logic                      mem_re;
    logic signed [TOTAL_W-1:0] tot_co;
    logic signed [TOTAL_W-1:0] tot_cg;

    // The register may be written at any time the block is idle; no wait is needed.
    assign i_cfg.ready = 1'b1;

    // Stage one moves on when the output register is empty or being drained, and a
    // new pixel request enters whenever stage one is free or moving on.
    assign s1_adv      = r_s1_valid && (!r_out_valid || o_res.ready);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign pix_acc     = i_pix.valid && i_pix.ready;

    always_comb begin
        // A width below two acts as two, one above the line store's reach as the maximum.
        w_cfg = WCMP_W'(r_line_width);
        if (w_cfg < WCMP_W'(2)) begin
            w_eff = WCMP_W'(2);
        end else if (w_cfg > WCMP_W'(MAX_WIDTH)) begin
            w_eff = WCMP_W'(MAX_WIDTH);
        end else begin
            w_eff = w_cfg;
        end

        // A frame start clears the position before this pixel is placed.
        eff_col  = i_pix.frame_start ? '0 : r_col;
        eff_odd  = i_pix.frame_start ? 1'b0 : r_row_odd;
        line_end = (WCMP_W'(eff_col) + WCMP_W'(1)) >= w_eff;

        // YCoCg-R lifting; every shift is arithmetic.
        co     = $signed({2'b00, i_pix.red}) - $signed({2'b00, i_pix.blue});
        lift_t = $signed({2'b00, i_pix.blue}) + (co >>> 1);
        cg     = $signed({2'b00, i_pix.green}) - lift_t;
        y_val  = lift_t + (cg >>> 1);

        // Horizontal pair sums of the left even-column pixel and this one.
        sco  = $signed({{(SUM_W-CHROMA_W){r_left_co[CHROMA_W-1]}}, r_left_co})
             + $signed({{(SUM_W-CHROMA_W){co[CHROMA_W-1]}}, co[CHROMA_W-1:0]});
        scg  = $signed({{(SUM_W-CHROMA_W){r_left_cg[CHROMA_W-1]}}, r_left_cg})
             + $signed({{(SUM_W-CHROMA_W){cg[CHROMA_W-1]}}, cg[CHROMA_W-1:0]});
        slot = eff_col[COL_W-1:1];

        // Even rows leave their pair sums behind at odd columns; odd rows pick them up.
        mem_we = pix_acc && eff_col[0] && !eff_odd;
        mem_re = pix_acc && eff_col[0] && eff_odd;

        // Four-pixel totals with the rounding offset; they are at least four.
        tot_co = TOTAL_W'(r_s1_sco) + TOTAL_W'($signed(r_rd_data[PAIR_W-1:SUM_W]))
               + TOTAL_W'(ROUND_OFFSET);
        tot_cg = TOTAL_W'(r_s1_scg) + TOTAL_W'($signed(r_rd_data[SUM_W-1:0]))
               + TOTAL_W'(ROUND_OFFSET);
    end

    // Line store: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_pair_mem[slot] <= {sco, scg};
        end
        if (mem_re) begin
            r_rd_data <= r_pair_mem[slot];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RESET;
            r_col        <= '0;
            r_row_odd    <= 1'b0;
            r_left_co    <= '0;
            r_left_cg    <= '0;
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_line_width <= i_cfg.line_width;
            end
            if (pix_acc) begin
                if (line_end) begin
                    r_col     <= '0;
                    r_row_odd <= !eff_odd;
                end else begin
                    r_col     <= eff_col + COL_W'(1);
                    r_row_odd <= eff_odd;
                end
                if (!eff_col[0]) begin
                    r_left_co <= co[CHROMA_W-1:0];
                    r_left_cg <= cg[CHROMA_W-1:0];
                end
            end
            if (pix_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_luma   <= y_val[COMP_W-1:0];
            r_s1_chroma <= eff_col[0] && eff_odd;
            r_s1_sco    <= sco;
            r_s1_scg    <= scg;
        end
        if (s1_adv) begin
            r_out_luma   <= r_s1_luma;
            r_out_chroma <= r_s1_chroma;
            r_out_co     <= r_s1_chroma ? tot_co[SUB_SHIFT+COMP_W-1:SUB_SHIFT] : '0;
            r_out_cg     <= r_s1_chroma ? tot_cg[SUB_SHIFT+COMP_W-1:SUB_SHIFT] : '0;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.luma         = r_out_luma;
    assign o_res.chroma_valid = r_out_chroma;
    assign o_res.co_sub       = r_out_co;
    assign o_res.cg_sub       = r_out_cg;

`ifndef SYNTHESIS
    // The line store is never written and read for the same pixel.
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("line store written and read in one cycle");

    // Store accesses only happen at odd columns.
    a_odd_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we || mem_re) |-> eff_col[0])
        else $error("line store touched at an even column");

    // A pixel held in stage one behind a stalled output is not lost.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_res.ready) |=> r_s1_valid)
        else $error("stage one dropped a pixel under stall");

    // Chroma fields are zero on results that do not close a block.
    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_chroma) |-> (r_out_co == '0 && r_out_cg == '0))
        else $error("chroma present without chroma_valid");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench of the RGB to YCoCg-R 4:2:0 converter: random stimulus and a predictor.
`timescale 1ns / 1ps

module tb_top;
    import ycc420_pkg::*;

    localparam int PLAN         = 0;     // model copy used while building the stimulus
    localparam int CHECK        = 1;     // model copy advanced on accepted requests
    localparam int RAND_PIXELS  = 1400;
    localparam int IDLE_LIMIT   = 1000;  // cycles without any handshake before giving up
    localparam int LONG_HOLD    = 96;    // one long receiver stall to fill the pipeline

    typedef struct packed {
        t_comp red;
        t_comp green;
        t_comp blue;
        logic  frame_start;
    } t_pix;

    typedef struct packed {
        t_comp luma;
        logic  chroma_valid;
        t_comp co_sub;
        t_comp cg_sub;
    } t_res;

    typedef enum logic [1:0] {REQ_PIXEL, REQ_WIDTH, REQ_DRAIN} t_req_kind;

    typedef struct packed {
        t_req_kind  kind;
        t_pix       pix;
        t_cfg_width width;
    } t_req;

    logic i_clk;
    logic i_rst_n;

    ycc420_pix_if pix_ch ();
    ycc420_res_if res_ch ();
    ycc420_cfg_if cfg_ch ();

    rgb_to_ycocg_r_420 u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // Two copies of the converter state: one steers stimulus generation, the other
    // predicts the results of requests as the block accepts them.
    t_cfg_width                 line_width_m [2];
    logic [COL_W-1:0]           pos_col      [2];
    logic                       row_odd      [2];
    logic signed [CHROMA_W-1:0] left_co      [2];
    logic signed [CHROMA_W-1:0] left_cg      [2];
    logic signed [SUM_W-1:0]    pair_co      [2][PAIR_DEPTH];
    logic signed [SUM_W-1:0]    pair_cg      [2][PAIR_DEPTH];
    bit                         pair_written [PAIR_DEPTH];

    t_req pending_reqs [$];
    t_res expected_res [$];

    int planned_pixels;
    int width_writes;
    int pixels_in;
    int results_out;
    int chroma_out;
    int mismatches;
    int idle_cycles;

    logic pix_acc;
    logic cfg_acc;
    int   gap_left;
    bit   pix_burst;
    int   res_wait;
    int   hold_left;
    bit   hold_done;
    bit   res_burst;

    // Convert one pixel on the chosen model copy: lifting, then pair sums that an even
    // row leaves behind and an odd row folds into the 2x2 average.
    function automatic t_res ycocg_convert(input int side, input t_pix px);
        int co, t, cg, y, wd, sco, scg;
        logic [PAIR_AW-1:0] slot;
        t_res r;
        r = '0;
        if (px.frame_start) begin
            pos_col[side] = '0;
            row_odd[side] = 1'b0;
        end
        wd = int'(line_width_m[side]);
        if (wd < 2) begin
            wd = 2;
        end
        if (wd > MAX_WIDTH) begin
            wd = MAX_WIDTH;
        end
        co = int'(px.red) - int'(px.blue);
        t  = int'(px.blue) + (co >>> 1);
        cg = int'(px.green) - t;
        y  = t + (cg >>> 1);
        slot = pos_col[side][COL_W-1:1];
        if (!pos_col[side][0]) begin
            left_co[side] = CHROMA_W'(co);
            left_cg[side] = CHROMA_W'(cg);
        end else begin
            sco = int'(left_co[side]) + co;
            scg = int'(left_cg[side]) + cg;
            if (!row_odd[side]) begin
                pair_co[side][slot] = SUM_W'(sco);
                pair_cg[side][slot] = SUM_W'(scg);
                if (side == PLAN) begin
                    pair_written[slot] = 1'b1;
                end
            end else begin
                r.chroma_valid = 1'b1;
                r.co_sub = 8'((sco + int'(pair_co[side][slot]) + ROUND_OFFSET) >>> SUB_SHIFT);
                r.cg_sub = 8'((scg + int'(pair_cg[side][slot]) + ROUND_OFFSET) >>> SUB_SHIFT);
            end
        end
        if (int'(pos_col[side]) + 1 >= wd) begin
            pos_col[side] = '0;
            row_odd[side] = ~row_odd[side];
        end else begin
            pos_col[side] = pos_col[side] + COL_W'(1);
        end
        r.luma = y[7:0];
        return r;
    endfunction

    // Components lean toward 0 and 255 now and then so the chroma extremes recur.
    function automatic t_comp rand_comp();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            return 8'd0;
        end else if (sel == 1) begin
            return 8'd255;
        end
        return t_comp'($urandom_range(0, 255));
    endfunction

    task automatic plan_pixel(input t_comp r, input t_comp g, input t_comp b, input logic fs);
        t_req q;
        q = '0;
        q.kind = REQ_PIXEL;
        q.pix.red = r;
        q.pix.green = g;
        q.pix.blue = b;
        q.pix.frame_start = fs;
        // An odd row must never reach a pair slot that no even row has filled, so such
        // a pixel opens a new frame instead.
        if (!fs && pos_col[PLAN][0] && row_odd[PLAN]
            && !pair_written[pos_col[PLAN][COL_W-1:1]]) begin
            q.pix.frame_start = 1'b1;
        end
        void'(ycocg_convert(PLAN, q.pix));
        pending_reqs.push_back(q);
        planned_pixels++;
    endtask

    task automatic plan_width(input int w);
        t_req q;
        q = '0;
        q.kind = REQ_WIDTH;
        q.width = t_cfg_width'(w);
        line_width_m[PLAN] = q.width;
        pending_reqs.push_back(q);
    endtask

    task automatic plan_drain();
        t_req q;
        q = '0;
        q.kind = REQ_DRAIN;
        pending_reqs.push_back(q);
    endtask

    task automatic plan_block(input t_comp r, input t_comp g, input t_comp b, input logic fs);
        plan_pixel(r, g, b, fs);
        plan_pixel(r, g, b, 1'b0);
        plan_pixel(r, g, b, 1'b0);
        plan_pixel(r, g, b, 1'b0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        int w, eff, n, sel;
        bit mid_line, huge;

        i_rst_n = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.red = '0;
        pix_ch.green = '0;
        pix_ch.blue = '0;
        pix_ch.frame_start = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.line_width = '0;
        res_ch.ready = 1'b0;

        for (int s = 0; s < 2; s++) begin
            line_width_m[s] = LINE_WIDTH_RESET;
            pos_col[s] = '0;
            row_odd[s] = 1'b0;
            left_co[s] = '0;
            left_cg[s] = '0;
        end

        // Directed: a zero width acts as two, so each group of four pixels is one 2x2
        // block, driving both chroma channels to their top and bottom codes.
        plan_width(0);
        plan_block(8'd255, 8'd0,   8'd0,   1'b1);
        plan_block(8'd0,   8'd0,   8'd255, 1'b0);
        plan_block(8'd0,   8'd255, 8'd0,   1'b0);
        plan_block(8'd255, 8'd0,   8'd255, 1'b0);
        plan_drain();
        // Odd width: the last pixel of each line sits alone on an even column.
        plan_width(3);
        plan_pixel(8'd0,   8'd0,   8'd0,   1'b1);
        plan_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        plan_pixel(8'd255, 8'd0,   8'd0,   1'b0);
        plan_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        plan_pixel(8'd0,   8'd0,   8'd0,   1'b0);
        plan_pixel(8'd0,   8'd255, 8'd255, 1'b0);
        plan_pixel(8'd17,  8'd200, 8'd99,  1'b0);

        // Random phases: mostly whole frames of small widths, with odd and clamped widths,
        // huge widths on short partial lines, mid-line width changes and broken frames.
        while (planned_pixels < RAND_PIXELS + 23) begin
            sel = $urandom_range(0, 19);
            mid_line = 1'b0;
            huge = 1'b0;
            if (sel < 12) begin
                w = 2 * $urandom_range(1, 8);
            end else if (sel < 14) begin
                w = 2 * $urandom_range(1, 7) + 1;
            end else if (sel < 15) begin
                w = $urandom_range(0, 1);
            end else if (sel < 16) begin
                huge = 1'b1;
                case ($urandom_range(0, 3))
                    0: w = MAX_WIDTH;
                    1: w = MAX_WIDTH + 1;
                    2: w = (1 << CFG_W) - 1;
                    default: w = $urandom_range(17, (1 << CFG_W) - 1);
                endcase
            end else begin
                w = $urandom_range(1, 16);
                mid_line = 1'b1;
            end
            plan_width(w);
            width_writes++;
            eff = (w < 2) ? 2 : w;
            n = huge ? $urandom_range(5, 30) : $urandom_range(2, 6) * eff;
            if ($urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, n);
            end
            for (int i = 0; i < n; i++) begin
                plan_pixel(rand_comp(), rand_comp(), rand_comp(),
                           (i == 0 && !mid_line) || ($urandom_range(0, 63) == 0));
            end
            if ($urandom_range(0, 9) == 0) begin
                plan_drain();
            end
        end

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        forever begin
            @(posedge i_clk);
            if (pending_reqs.size() == 0 && !pix_ch.valid && !cfg_ch.valid
                && expected_res.size() == 0) begin
                break;
            end
        end
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d pixels, %0d chroma blocks and %0d width writes,",
                 pixels_in, chroma_out, width_writes + 2);
        $display("including clamped, odd, huge and mid-line widths; %0d mismatches.",
                 mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Sender: offers queued requests at the falling edge, with a drawn gap before each
    // pixel; a width write or a drain marker waits until every result is back.
    always @(negedge i_clk) begin
        logic       nxt_pv;
        logic       nxt_cv;
        t_pix       nxt_px;
        t_cfg_width nxt_w;
        t_req       head;
        nxt_pv = pix_ch.valid;
        nxt_cv = cfg_ch.valid;
        nxt_px.red = pix_ch.red;
        nxt_px.green = pix_ch.green;
        nxt_px.blue = pix_ch.blue;
        nxt_px.frame_start = pix_ch.frame_start;
        nxt_w = cfg_ch.line_width;
        if (pix_ch.valid && pix_acc) begin
            nxt_pv = 1'b0;
            gap_left = pix_burst ? 0 : $urandom_range(0, 7);
            if ($urandom_range(0, 47) == 0) begin
                pix_burst = !pix_burst;
            end
        end
        if (cfg_ch.valid && cfg_acc) begin
            nxt_cv = 1'b0;
        end
        if (i_rst_n && !nxt_pv && !nxt_cv) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_reqs.size() > 0) begin
                head = pending_reqs[0];
                case (head.kind)
                    REQ_PIXEL: begin
                        nxt_pv = 1'b1;
                        nxt_px = head.pix;
                        void'(pending_reqs.pop_front());
                    end
                    REQ_WIDTH: begin
                        if (expected_res.size() == 0) begin
                            nxt_cv = 1'b1;
                            nxt_w = head.width;
                            void'(pending_reqs.pop_front());
                        end
                    end
                    default: begin
                        if (expected_res.size() == 0) begin
                            void'(pending_reqs.pop_front());
                        end
                    end
                endcase
            end
        end
        pix_ch.valid <= nxt_pv;
        pix_ch.red <= nxt_px.red;
        pix_ch.green <= nxt_px.green;
        pix_ch.blue <= nxt_px.blue;
        pix_ch.frame_start <= nxt_px.frame_start;
        cfg_ch.valid <= nxt_cv;
        cfg_ch.line_width <= nxt_w;
    end

    // Receiver: a drawn wait before each result, bursts without waits, and one long
    // stall while the sender keeps offering pixels so that the block backs up.
    always @(negedge i_clk) begin
        logic nxt_rdy;
        if (res_ch.valid && res_ch.ready) begin
            res_wait = res_burst ? 0 : $urandom_range(0, 7);
            if ($urandom_range(0, 47) == 0) begin
                res_burst = !res_burst;
            end
        end
        if (!hold_done && results_out >= 300 && pix_ch.valid) begin
            hold_left = LONG_HOLD;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            nxt_rdy = 1'b0;
        end else if (res_wait > 0) begin
            res_wait--;
            nxt_rdy = 1'b0;
        end else begin
            nxt_rdy = 1'b1;
        end
        res_ch.ready <= nxt_rdy;
    end

    // Monitor: handshakes are sampled at the rising edge; accepted pixels are predicted
    // on the checking copy and results are compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_pix px;
        t_res got;
        t_res want;
        pix_acc <= pix_ch.valid && pix_ch.ready && i_rst_n;
        cfg_acc <= cfg_ch.valid && cfg_ch.ready && i_rst_n;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                line_width_m[CHECK] = cfg_ch.line_width;
            end
            if (pix_ch.valid && pix_ch.ready) begin
                px.red = pix_ch.red;
                px.green = pix_ch.green;
                px.blue = pix_ch.blue;
                px.frame_start = pix_ch.frame_start;
                expected_res.push_back(ycocg_convert(CHECK, px));
                pixels_in++;
            end
            if (res_ch.valid && res_ch.ready) begin
                got.luma = res_ch.luma;
                got.chroma_valid = res_ch.chroma_valid;
                got.co_sub = res_ch.co_sub;
                got.cg_sub = res_ch.cg_sub;
                results_out++;
                if (got.chroma_valid) begin
                    chroma_out++;
                end
                if (expected_res.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Unexpected result %0d: luma %0d chroma %0b co %0d cg %0d",
                                 results_out, got.luma, got.chroma_valid,
                                 got.co_sub, got.cg_sub);
                    end
                end else begin
                    want = expected_res.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"Result %0d differs: luma %0d/%0d chroma %0b/%0b",
                                      " co %0d/%0d cg %0d/%0d (expected/actual)"},
                                     results_out, want.luma, got.luma, want.chroma_valid,
                                     got.chroma_valid, want.co_sub, got.co_sub,
                                     want.cg_sub, got.cg_sub);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: too long without any handshake means the block has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d idle cycles with %0d results outstanding.",
                     idle_cycles, expected_res.size());
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
